// ----- sv/b64d_pkg.sv -----
package b64d_pkg;

	localparam int unsigned CHAR_W   = 8;
	localparam int unsigned SEXTET_W = 6;
	localparam int unsigned COUNT_W  = 16;
	localparam int unsigned GROUP_N  = 3;

	localparam logic [CHAR_W-1:0] CHAR_PAD    = 8'h3D; // '='
	localparam logic [CHAR_W-1:0] CHAR_UP_A   = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_UP_Z   = 8'h5A;
	localparam logic [CHAR_W-1:0] CHAR_LO_A   = 8'h61;
	localparam logic [CHAR_W-1:0] CHAR_LO_Z   = 8'h7A;
	localparam logic [CHAR_W-1:0] CHAR_DIG_0  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_DIG_9  = 8'h39;
	localparam logic [CHAR_W-1:0] CHAR_PLUS   = 8'h2B;
	localparam logic [CHAR_W-1:0] CHAR_MINUS  = 8'h2D;
	localparam logic [CHAR_W-1:0] CHAR_SLASH  = 8'h2F;
	localparam logic [CHAR_W-1:0] CHAR_UNDER  = 8'h5F;

	localparam logic [SEXTET_W-1:0] SX_LOWER_BASE = 6'd26;
	localparam logic [SEXTET_W-1:0] SX_DIGIT_BASE = 6'd52;
	localparam logic [SEXTET_W-1:0] SX_62         = 6'd62;
	localparam logic [SEXTET_W-1:0] SX_63         = 6'd63;

	localparam logic [COUNT_W-1:0] MAX_BYTES_RESET = 16'hFFFF;

	// One accepted character's worth of output words, drained one per cycle while out_ready is high.
	typedef struct packed {
		logic [GROUP_N-1:0][CHAR_W-1:0] data;
		logic [1:0]                     last_idx;
		logic [COUNT_W-1:0]             base;
		logic                           empty;
		logic                           msg_end;
	} b64d_bundle_t;

	typedef struct packed {
		logic    ok;
		logic [SEXTET_W-1:0] val;
	} b64d_sextet_t;

	function automatic b64d_sextet_t sextet_of(input logic [CHAR_W-1:0] c);
		b64d_sextet_t r;
		logic [CHAR_W-1:0] d;
		r.ok  = 1'b1;
		r.val = '0;
		d     = '0;
		priority if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
			d     = c - CHAR_UP_A;
			r.val = d[SEXTET_W-1:0];
		end else if (c >= CHAR_LO_A && c <= CHAR_LO_Z) begin
			d     = c - CHAR_LO_A;
			r.val = d[SEXTET_W-1:0] + SX_LOWER_BASE;
		end else if (c >= CHAR_DIG_0 && c <= CHAR_DIG_9) begin
			d     = c - CHAR_DIG_0;
			r.val = d[SEXTET_W-1:0] + SX_DIGIT_BASE;
		end else if (c == CHAR_PLUS || c == CHAR_MINUS) begin
			r.val = SX_62;
		end else if (c == CHAR_SLASH || c == CHAR_UNDER) begin
			r.val = SX_63;
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

endpackage

// ----- sv/b64d_decode.sv -----
module b64d_decode import b64d_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic [CHAR_W-1:0]    char_in,
	input  logic                 end_of_input,
	input  logic                 cfg_write_en,
	input  logic [COUNT_W-1:0]   cfg_write_data,
	output logic                 push,
	output b64d_bundle_t         bundle
);

	logic [COUNT_W-1:0]  max_q;
	logic [COUNT_W-1:0]  emitted_q;
	logic [1:0]          cnt_q;
	logic                stop_q;
	logic [SEXTET_W-1:0] store_q [GROUP_N];

	b64d_sextet_t        sx;
	logic                is_pad;
	logic                ins;
	logic [SEXTET_W-1:0] g [GROUP_N+1];
	logic [2:0]          gc;
	logic                flush;
	logic [1:0]          nbytes;
	logic [COUNT_W-1:0]  room;
	logic [1:0]          nk;

	always_comb begin
		sx     = sextet_of(char_in);
		is_pad = (char_in == CHAR_PAD) && !stop_q;
		ins    = sx.ok && !stop_q && (char_in != CHAR_PAD);

		// Sextets past the fill count read as zero, so the store never needs clearing.
		for (int i = 0; i < GROUP_N; i++) begin
			if (2'(i) < cnt_q) begin
				g[i] = store_q[i];
			end else if (ins && 2'(i) == cnt_q) begin
				g[i] = sx.val;
			end else begin
				g[i] = '0;
			end
		end
		g[GROUP_N] = (ins && cnt_q == 2'd3) ? sx.val : '0;

		gc    = {1'b0, cnt_q} + {2'b00, ins};
		flush = !stop_q && (is_pad || gc == 3'd4 || end_of_input);

		unique case (gc)
			3'd0:      nbytes = 2'd0;
			3'd1,
			3'd2:      nbytes = 2'd1;
			3'd3:      nbytes = 2'd2;
			default:   nbytes = 2'd3;
		endcase
		if (!flush) begin
			nbytes = 2'd0;
		end

		room = (max_q > emitted_q) ? (max_q - emitted_q) : '0;
		nk   = (room >= {14'd0, nbytes}) ? nbytes : room[1:0];

		bundle.data[0]  = {g[0], g[1][5:4]};
		bundle.data[1]  = {g[1][3:0], g[2][5:2]};
		bundle.data[2]  = {g[2][1:0], g[3]};
		bundle.last_idx = (nk == 2'd0) ? 2'd0 : nk - 2'd1;
		bundle.base     = emitted_q;
		bundle.empty    = (nk == 2'd0);
		bundle.msg_end  = end_of_input;
		push            = accept && (nk != 2'd0 || end_of_input);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q     <= MAX_BYTES_RESET;
			emitted_q <= '0;
			cnt_q     <= '0;
			stop_q    <= 1'b0;
		end else begin
			if (cfg_write_en) begin
				max_q <= cfg_write_data;
			end
			if (accept) begin
				if (end_of_input) begin
					emitted_q <= '0;
					cnt_q     <= '0;
					stop_q    <= 1'b0;
				end else begin
					emitted_q <= emitted_q + {14'd0, nk};
					stop_q    <= stop_q | is_pad;
					if (flush) begin
						cnt_q <= '0;
					end else if (ins) begin
						cnt_q <= cnt_q + 2'd1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && ins && !flush && cnt_q != 2'd3) begin
			store_q[cnt_q] <= sx.val;
		end
	end

	a_msg_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && end_of_input |=> emitted_q == '0 && cnt_q == '0 && !stop_q)
		else $error("decoder state not cleared after message end");

	a_stop_holds: assert property (@(posedge clk) disable iff (!arst_n)
		stop_q && !(accept && end_of_input) |=> stop_q && $stable(cnt_q))
		else $error("decoding resumed after pad before message end");

	a_no_push_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |-> !push)
		else $error("bundle pushed without an accepted word");

endmodule

// ----- sv/b64d_serializer.sv -----
module b64d_serializer import b64d_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  b64d_bundle_t       bundle,
	output logic               can_take,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [CHAR_W-1:0]  data_byte,
	output logic               byte_valid,
	output logic               run_last,
	output logic               message_end,
	output logic [COUNT_W-1:0] bytes_so_far
);

	logic         full_q;
	logic [1:0]   idx_q;
	b64d_bundle_t bundle_s1;
	logic         take;
	logic         last_word;

	always_comb begin
		last_word    = (idx_q == bundle_s1.last_idx);
		take         = full_q && out_ready;
		can_take     = !full_q || (out_ready && last_word);
		out_valid    = full_q;
		byte_valid   = !bundle_s1.empty;
		data_byte    = bundle_s1.empty ? '0 : bundle_s1.data[idx_q];
		bytes_so_far = bundle_s1.empty ? bundle_s1.base
		                               : bundle_s1.base + {14'd0, idx_q} + 16'd1;
		run_last     = last_word;
		message_end  = last_word && bundle_s1.msg_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
			idx_q  <= '0;
		end else begin
			if (push) begin
				full_q <= 1'b1;
				idx_q  <= '0;
			end else if (take) begin
				if (last_word) begin
					full_q <= 1'b0;
					idx_q  <= '0;
				end else begin
					idx_q <= idx_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			bundle_s1 <= bundle;
		end
	end

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		full_q |-> idx_q <= bundle_s1.last_idx)
		else $error("word index ran past the end of the bundle");

	a_load_start: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> full_q && idx_q == '0)
		else $error("new bundle did not start at its first word");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> can_take)
		else $error("bundle pushed while previous one still pending");

endmodule

// ----- sv/base64_lenient_stream_decoder_unit.sv -----
// A character accepted in one cycle shows its first output word in the next
// cycle. Throughput: one character per cycle while out_ready is high and each
// yields at most one word; a character that yields two or three words holds
// the input until all but its last word have drained, as the single output
// register drains one a cycle while out_ready is high. Reset (arst_n low)
// clears the group, pad stop and byte count and sets the output limit to 65535.
module base64_lenient_stream_decoder_unit import b64d_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [CHAR_W-1:0]  char_in,
	input  logic               end_of_input,
	input  logic               cfg_write_en,
	input  logic [COUNT_W-1:0] cfg_write_data,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [CHAR_W-1:0]  data_byte,
	output logic               byte_valid,
	output logic               run_last,
	output logic               message_end,
	output logic [COUNT_W-1:0] bytes_so_far
);

	logic         accept;
	logic         push;
	b64d_bundle_t bundle;

	assign accept = in_valid && in_ready;

	b64d_decode u_decode (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.char_in        (char_in),
		.end_of_input   (end_of_input),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.push           (push),
		.bundle         (bundle)
	);

	b64d_serializer u_serializer (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.bundle       (bundle),
		.can_take     (in_ready),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.data_byte    (data_byte),
		.byte_valid   (byte_valid),
		.run_last     (run_last),
		.message_end  (message_end),
		.bytes_so_far (bytes_so_far)
	);

endmodule
